[rtl/gqld_pkg.sv]
// gqld_pkg: shared types, widths and codes for the gaussian log density block
// no dependencies; used by the interfaces, the arithmetic units and the top level

package gqld_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 16;
   localparam int CHANGE_W   = 17;
   localparam int MIX_W      = 20;
   localparam int LD_W       = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int CFG_LEN_W  = 5;
   localparam int KIND_W     = 3;

   // multiplier operands: a is 64 bits, b is a centred count of up to 38 bits
   localparam int OPA_W  = 64;
   localparam int OPB_W  = 38;
   localparam int HALF_B = 19;
   localparam int PROD_W = OPA_W + OPB_W;

   localparam logic signed [LD_W-1:0] LD_MAX = {1'b0, {(LD_W-1){1'b1}}};
   localparam logic signed [LD_W-1:0] LD_MIN = {1'b1, {(LD_W-1){1'b0}}};

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_LOAD_MEAN = 2'd0,
      REQ_LOAD_PREC = 2'd1,
      REQ_LOAD_STAT = 2'd2,
      REQ_COMPUTE   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_LENGTH = 3'd0,
      CSR_MARGINAL_KIND = 3'd1,
      CSR_JOINT_KIND_A  = 3'd2,
      CSR_JOINT_KIND_B  = 3'd3,
      CSR_MIXING_KIND   = 3'd4
   } csr_index_type;

   localparam logic [KIND_W-1:0] MARGINAL_GAUSS_A = 3'd1;
   localparam logic [KIND_W-1:0] MARGINAL_GAUSS_B = 3'd2;
   localparam logic [KIND_W-1:0] JOINT_NONE       = 3'd0;
   localparam logic [KIND_W-1:0] MIXING_NONE      = 3'd0;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  mean;
      logic        [COUNT_W-1:0]  count;
      logic signed [CHANGE_W-1:0] change;
   } bin_word_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_IN_RD,
      ST_IN_X,
      ST_IN_GO,
      ST_IN_WAIT,
      ST_OUT_RD,
      ST_OUT_X,
      ST_OUT_GO,
      ST_OUT_WAIT,
      ST_BLK_END,
      ST_MIX_RD,
      ST_MIX_X,
      ST_MIX_GO,
      ST_MIX_WAIT,
      ST_DIV_WAIT,
      ST_PASS_END,
      ST_DONE
   } state_type;

   function automatic logic signed [LD_W-1:0] sat_add(input logic signed [LD_W-1:0] a,
                                                      input logic signed [LD_W-1:0] b);
      logic signed [LD_W:0] sum;
      sum = {a[LD_W-1], a} + {b[LD_W-1], b};
      if (sum[LD_W] != sum[LD_W-1]) begin
         return sum[LD_W] ? LD_MIN : LD_MAX;
      end
      return sum[LD_W-1:0];
   endfunction

endpackage

[rtl/gqld_if.sv]
// gqld channel interfaces: request, response and register write channels
// depends on gqld_pkg for field widths

interface gqld_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [gqld_pkg::REQ_TYPE_W-1:0] req_type;
   logic        [gqld_pkg::INDEX_W-1:0]    index;
   logic signed [gqld_pkg::VALUE_W-1:0]    value;
   logic        [gqld_pkg::COUNT_W-1:0]    count_now;
   logic signed [gqld_pkg::CHANGE_W-1:0]   count_change;
   logic        [gqld_pkg::MIX_W-1:0]      mix_now;
   logic        [gqld_pkg::MIX_W-1:0]      mix_prop;

   modport source(output valid, req_type, index, value, count_now, count_change,
                  mix_now, mix_prop, input ready);
   modport sink(input valid, req_type, index, value, count_now, count_change,
                mix_now, mix_prop, output ready);
endinterface

interface gqld_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             computed;
   logic signed [gqld_pkg::LD_W-1:0] log_density_now;
   logic signed [gqld_pkg::LD_W-1:0] log_density_prop;

   modport source(output valid, computed, log_density_now, log_density_prop, input ready);
   modport sink(input valid, computed, log_density_now, log_density_prop, output ready);
endinterface

interface gqld_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gqld_pkg::CSR_IDX_W-1:0]    index;
   logic [gqld_pkg::CSR_DATA_W-1:0]   data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[rtl/gaussian_quadratic_log_density_top.sv]
// gaussian_quadratic_log_density_top: stores, sequencer and result register
// depends on gqld_pkg, the gqld interfaces, gqld_mulq and gqld_div
//
// usage
//   req_bus carries loads and computes. a load (mean, precision entry or
//   degree stat) is written into its store in the cycle of its transaction
//   and gives no response; loads are taken one per cycle while idle.
//   a compute walks both quadratic forms and the mixing term for the
//   current and the proposed counts and returns one response on rsp_bus.
//   csr_bus writes the five registers; it is always ready.
// arithmetic and throughput
//   each multiply-accumulate runs in the shared multiplier (four partial
//   products) and the mixing term needs the one-bit-a-cycle divider once
//   per state. req_bus is not ready while a compute runs. a compute the
//   model kinds do not allow answers with computed low.
// reset and stalls
//   reset clears the sequencer, the response valid and the registers to
//   their defaults; the stores hold nothing defined until loaded.
//   a response waits in the output register while rsp_bus stalls; loads
//   are still taken, a further compute waits for the register to free.

module gaussian_quadratic_log_density_top #(
   parameter int MAX_BINS = 16
) (
   input  logic        clock,
   input  logic        reset,
   gqld_req_if.sink    req_bus,
   gqld_rsp_if.source  rsp_bus,
   gqld_csr_if.sink    csr_bus
);

   localparam int BIN_DEPTH  = 2 * MAX_BINS + 1;
   localparam int STAT_DEPTH = 2 * MAX_BINS;
   localparam int PREC_DEPTH = 2 * MAX_BINS * MAX_BINS + 1;
   localparam int BIN_AW     = $clog2(BIN_DEPTH);
   localparam int PREC_AW    = $clog2(PREC_DEPTH);
   localparam int LEN_W      = $clog2(MAX_BINS + 1);
   localparam int LD_W       = gqld_pkg::LD_W;
   localparam int OPB_W      = gqld_pkg::OPB_W;

   // ---------------------------------------------------------------- registers
   logic [gqld_pkg::CFG_LEN_W-1:0] active_length_ff;
   logic [gqld_pkg::KIND_W-1:0]    marginal_kind_ff, joint_kind_a_ff;
   logic [gqld_pkg::KIND_W-1:0]    joint_kind_b_ff, mixing_kind_ff;
   logic                           csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= gqld_pkg::CFG_LEN_W'(16);
         marginal_kind_ff <= gqld_pkg::MARGINAL_GAUSS_A;
         joint_kind_a_ff  <= gqld_pkg::JOINT_NONE;
         joint_kind_b_ff  <= gqld_pkg::JOINT_NONE;
         mixing_kind_ff   <= gqld_pkg::KIND_W'(1);
      end else if (csr_write) begin
         priority case (gqld_pkg::csr_index_type'(csr_bus.index))
            gqld_pkg::CSR_ACTIVE_LENGTH: active_length_ff <= csr_bus.data;
            gqld_pkg::CSR_MARGINAL_KIND: marginal_kind_ff <= csr_bus.data[2:0];
            gqld_pkg::CSR_JOINT_KIND_A:  joint_kind_a_ff  <= csr_bus.data[2:0];
            gqld_pkg::CSR_JOINT_KIND_B:  joint_kind_b_ff  <= csr_bus.data[2:0];
            gqld_pkg::CSR_MIXING_KIND:   mixing_kind_ff   <= csr_bus.data[2:0];
            default: ;
         endcase
      end
   end

   // bins beyond the built size act as the built size
   logic [LEN_W-1:0] len_cfg;
   logic             allowed;

   assign len_cfg = (32'(active_length_ff) > MAX_BINS) ? LEN_W'(MAX_BINS)
                                                      : LEN_W'(active_length_ff);
   assign allowed = ((marginal_kind_ff == gqld_pkg::MARGINAL_GAUSS_A) ||
                     (marginal_kind_ff == gqld_pkg::MARGINAL_GAUSS_B)) &&
                    (joint_kind_a_ff == gqld_pkg::JOINT_NONE) &&
                    (joint_kind_b_ff == gqld_pkg::JOINT_NONE) &&
                    (mixing_kind_ff != gqld_pkg::MIXING_NONE);

   // ---------------------------------------------------------------- sequencer state
   gqld_pkg::state_type state_ff, state_in;

   logic                     pass_ff, pass_in;
   logic                     blk_ff, blk_in;
   logic [LEN_W-1:0]         i_ff, i_in, j_ff, j_in, len_ff, len_in;
   logic [BIN_AW-1:0]        base_ff, base_in;
   logic [PREC_AW-1:0]       paddr_ff, paddr_in;
   logic signed [LD_W-1:0]   inner_ff, inner_in, q_ff, q_in, s_ff, s_in;
   logic signed [OPB_W-1:0]  x_ff, x_in;
   logic signed [gqld_pkg::VALUE_W-1:0] p_ff, p_in;
   logic [gqld_pkg::MIX_W-1:0] mix_now_ff, mix_now_in, mix_prop_ff, mix_prop_in;
   logic signed [LD_W-1:0]   ld_now_ff, ld_now_in, ld_prop_ff, ld_prop_in;
   logic                     computed_ff, computed_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_computed_ff, rsp_computed_in;
   logic signed [LD_W-1:0]   rsp_now_ff, rsp_now_in, rsp_prop_ff, rsp_prop_in;

   // ---------------------------------------------------------------- request decode
   logic req_take, is_compute, is_mean, is_prec, is_stat;
   logic [31:0] idx_ext;

   assign req_bus.ready = (state_ff == gqld_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign idx_ext       = 32'(req_bus.index);
   assign is_compute    = req_take && (req_bus.req_type == gqld_pkg::REQ_COMPUTE);
   assign is_mean       = req_take && (req_bus.req_type == gqld_pkg::REQ_LOAD_MEAN) &&
                          (idx_ext < BIN_DEPTH);
   assign is_prec       = req_take && (req_bus.req_type == gqld_pkg::REQ_LOAD_PREC) &&
                          (idx_ext < PREC_DEPTH);
   assign is_stat       = req_take && (req_bus.req_type == gqld_pkg::REQ_LOAD_STAT) &&
                          (idx_ext < STAT_DEPTH);

   // ---------------------------------------------------------------- stores
   // means and stats share one word per bin, written field by field
   gqld_pkg::bin_word_type              bin_mem [BIN_DEPTH];
   logic signed [gqld_pkg::VALUE_W-1:0] prec_mem [PREC_DEPTH];
   gqld_pkg::bin_word_type              bin_rd_ff;
   logic signed [gqld_pkg::VALUE_W-1:0] prec_rd_ff;
   logic [BIN_AW-1:0]                   bin_raddr;
   logic [PREC_AW-1:0]                  prec_raddr;

   always_ff @(posedge clock) begin
      if (is_mean) begin
         bin_mem[idx_ext[BIN_AW-1:0]].mean <= req_bus.value;
      end
      if (is_stat) begin
         bin_mem[idx_ext[BIN_AW-1:0]].count  <= req_bus.count_now;
         bin_mem[idx_ext[BIN_AW-1:0]].change <= req_bus.count_change;
      end
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   always_ff @(posedge clock) begin
      if (is_prec) begin
         prec_mem[idx_ext[PREC_AW-1:0]] <= req_bus.value;
      end
      prec_rd_ff <= prec_mem[prec_raddr];
   end

   // ---------------------------------------------------------------- arithmetic units
   logic                         mul_start, mul_done, div_start, div_done;
   logic signed [gqld_pkg::OPA_W-1:0] mul_a;
   logic signed [LD_W-1:0]       mul_res, div_res;
   logic [gqld_pkg::PROD_W-1:0]  mul_prod;

   gqld_mulq u_mulq (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (x_ff),
      .done    (mul_done),
      .result  (mul_res),
      .product (mul_prod)
   );

   gqld_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (mul_prod),
      .divisor (p_ff),
      .done    (div_done),
      .result  (div_res)
   );

   // ---------------------------------------------------------------- centred values
   logic signed [17:0]       count_sel;
   logic signed [OPB_W-1:0]  x_calc, d_calc, mean_ext;
   logic [gqld_pkg::MIX_W-1:0] mix_sel;
   logic signed [LD_W-1:0]   s_adj, ld_calc;
   logic                     j_last, i_last, out_free;

   assign mean_ext  = {{(OPB_W-gqld_pkg::VALUE_W){bin_rd_ff.mean[gqld_pkg::VALUE_W-1]}},
                       bin_rd_ff.mean};
   assign count_sel = $signed({2'b00, bin_rd_ff.count}) +
                      (pass_ff ? $signed({bin_rd_ff.change[gqld_pkg::CHANGE_W-1],
                                          bin_rd_ff.change}) : 18'sd0);
   assign x_calc    = $signed({{(OPB_W-34){count_sel[17]}}, count_sel, 16'h0000}) - mean_ext;
   assign mix_sel   = pass_ff ? mix_prop_ff : mix_now_ff;
   assign d_calc    = $signed({2'b00, mix_sel, 16'h0000}) - mean_ext;

   // -(s/2) with the halving toward zero
   assign s_adj   = s_ff + $signed({{(LD_W-1){1'b0}}, s_ff[LD_W-1]});
   assign ld_calc = -(s_adj >>> 1);

   assign j_last   = ((LEN_W+1)'(j_ff) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_ff);
   assign i_last   = ((LEN_W+1)'(i_ff) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_ff);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gqld_pkg::ST_IDLE: begin
            if (is_compute) begin
               if (!allowed) begin
                  state_in = gqld_pkg::ST_DONE;
               end else if (len_cfg == '0) begin
                  state_in = gqld_pkg::ST_MIX_RD;
               end else begin
                  state_in = gqld_pkg::ST_IN_RD;
               end
            end
         end
         gqld_pkg::ST_IN_RD:   state_in = gqld_pkg::ST_IN_X;
         gqld_pkg::ST_IN_X:    state_in = gqld_pkg::ST_IN_GO;
         gqld_pkg::ST_IN_GO:   state_in = gqld_pkg::ST_IN_WAIT;
         gqld_pkg::ST_IN_WAIT: begin
            if (mul_done) begin
               state_in = j_last ? gqld_pkg::ST_OUT_RD : gqld_pkg::ST_IN_RD;
            end
         end
         gqld_pkg::ST_OUT_RD:   state_in = gqld_pkg::ST_OUT_X;
         gqld_pkg::ST_OUT_X:    state_in = gqld_pkg::ST_OUT_GO;
         gqld_pkg::ST_OUT_GO:   state_in = gqld_pkg::ST_OUT_WAIT;
         gqld_pkg::ST_OUT_WAIT: begin
            if (mul_done) begin
               state_in = i_last ? gqld_pkg::ST_BLK_END : gqld_pkg::ST_IN_RD;
            end
         end
         gqld_pkg::ST_BLK_END: state_in = blk_ff ? gqld_pkg::ST_MIX_RD : gqld_pkg::ST_IN_RD;
         gqld_pkg::ST_MIX_RD:  state_in = gqld_pkg::ST_MIX_X;
         gqld_pkg::ST_MIX_X:   state_in = gqld_pkg::ST_MIX_GO;
         gqld_pkg::ST_MIX_GO:  state_in = gqld_pkg::ST_MIX_WAIT;
         gqld_pkg::ST_MIX_WAIT: begin
            if (mul_done) begin
               state_in = gqld_pkg::ST_DIV_WAIT;
            end
         end
         gqld_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = gqld_pkg::ST_PASS_END;
            end
         end
         gqld_pkg::ST_PASS_END: begin
            if (pass_ff) begin
               state_in = gqld_pkg::ST_DONE;
            end else if (len_ff == '0) begin
               state_in = gqld_pkg::ST_MIX_RD;
            end else begin
               state_in = gqld_pkg::ST_IN_RD;
            end
         end
         gqld_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = gqld_pkg::ST_IDLE;
            end
         end
         default: state_in = gqld_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs and datapath
   always_comb begin
      pass_in         = pass_ff;
      blk_in          = blk_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      len_in          = len_ff;
      base_in         = base_ff;
      paddr_in        = paddr_ff;
      inner_in        = inner_ff;
      q_in            = q_ff;
      s_in            = s_ff;
      x_in            = x_ff;
      p_in            = p_ff;
      mix_now_in      = mix_now_ff;
      mix_prop_in     = mix_prop_ff;
      ld_now_in       = ld_now_ff;
      ld_prop_in      = ld_prop_ff;
      computed_in     = computed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_computed_in = rsp_computed_ff;
      rsp_now_in      = rsp_now_ff;
      rsp_prop_in     = rsp_prop_ff;
      bin_raddr       = base_ff + BIN_AW'(j_ff);
      prec_raddr      = paddr_ff;
      mul_start       = 1'b0;
      mul_a           = {{(gqld_pkg::OPA_W-gqld_pkg::VALUE_W){p_ff[gqld_pkg::VALUE_W-1]}}, p_ff};
      div_start       = 1'b0;

      unique case (state_ff)
         gqld_pkg::ST_IDLE: begin
            if (is_compute) begin
               pass_in     = 1'b0;
               blk_in      = 1'b0;
               i_in        = '0;
               j_in        = '0;
               len_in      = len_cfg;
               base_in     = '0;
               paddr_in    = '0;
               inner_in    = '0;
               q_in        = '0;
               s_in        = '0;
               mix_now_in  = req_bus.mix_now;
               mix_prop_in = req_bus.mix_prop;
               computed_in = allowed;
               ld_now_in   = '0;
               ld_prop_in  = '0;
            end
         end
         gqld_pkg::ST_IN_RD: ;
         gqld_pkg::ST_IN_X: begin
            x_in = x_calc;
            p_in = prec_rd_ff;
         end
         gqld_pkg::ST_IN_GO: mul_start = 1'b1;
         gqld_pkg::ST_IN_WAIT: begin
            if (mul_done) begin
               inner_in = gqld_pkg::sat_add(inner_ff, mul_res);
               paddr_in = paddr_ff + PREC_AW'(1);
               j_in     = j_last ? '0 : j_ff + LEN_W'(1);
            end
         end
         gqld_pkg::ST_OUT_RD: bin_raddr = base_ff + BIN_AW'(i_ff);
         gqld_pkg::ST_OUT_X:  x_in = x_calc;
         gqld_pkg::ST_OUT_GO: begin
            mul_start = 1'b1;
            mul_a     = inner_ff;
         end
         gqld_pkg::ST_OUT_WAIT: begin
            if (mul_done) begin
               q_in     = gqld_pkg::sat_add(q_ff, mul_res);
               inner_in = '0;
               i_in     = i_last ? '0 : i_ff + LEN_W'(1);
            end
         end
         gqld_pkg::ST_BLK_END: begin
            s_in = gqld_pkg::sat_add(s_ff, q_ff);
            q_in = '0;
            if (!blk_ff) begin
               blk_in  = 1'b1;
               base_in = BIN_AW'(len_ff);
            end
         end
         gqld_pkg::ST_MIX_RD: bin_raddr = BIN_AW'(len_ff) << 1;
         gqld_pkg::ST_MIX_X: begin
            x_in = d_calc;
            p_in = prec_rd_ff;
         end
         gqld_pkg::ST_MIX_GO: begin
            mul_start = 1'b1;
            mul_a     = {{(gqld_pkg::OPA_W-OPB_W){x_ff[OPB_W-1]}}, x_ff};
         end
         gqld_pkg::ST_MIX_WAIT: div_start = mul_done;
         gqld_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               s_in = gqld_pkg::sat_add(s_ff, div_res);
            end
         end
         gqld_pkg::ST_PASS_END: begin
            if (pass_ff) begin
               ld_prop_in = ld_calc;
            end else begin
               ld_now_in = ld_calc;
               pass_in   = 1'b1;
               blk_in    = 1'b0;
               i_in      = '0;
               j_in      = '0;
               base_in   = '0;
               paddr_in  = '0;
               inner_in  = '0;
               q_in      = '0;
               s_in      = '0;
            end
         end
         gqld_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_computed_in = computed_ff;
               rsp_now_in      = ld_now_ff;
               rsp_prop_in     = ld_prop_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gqld_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff         <= pass_in;
      blk_ff          <= blk_in;
      i_ff            <= i_in;
      j_ff            <= j_in;
      len_ff          <= len_in;
      base_ff         <= base_in;
      paddr_ff        <= paddr_in;
      inner_ff        <= inner_in;
      q_ff            <= q_in;
      s_ff            <= s_in;
      x_ff            <= x_in;
      p_ff            <= p_in;
      mix_now_ff      <= mix_now_in;
      mix_prop_ff     <= mix_prop_in;
      ld_now_ff       <= ld_now_in;
      ld_prop_ff      <= ld_prop_in;
      computed_ff     <= computed_in;
      rsp_computed_ff <= rsp_computed_in;
      rsp_now_ff      <= rsp_now_in;
      rsp_prop_ff     <= rsp_prop_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.computed         = rsp_computed_ff;
   assign rsp_bus.log_density_now  = rsp_now_ff;
   assign rsp_bus.log_density_prop = rsp_prop_ff;

endmodule

[rtl/gqld_mulq.sv]
// gqld_mulq: sequential signed multiplier, four 32x19 partial products
// gives the raw magnitude product and the Q.16 rescaled, saturated result; uses gqld_pkg

module gqld_mulq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [gqld_pkg::OPA_W-1:0]   op_a,
   input  logic signed [gqld_pkg::OPB_W-1:0]   op_b,
   output logic                                done,
   output logic signed [gqld_pkg::LD_W-1:0]    result,
   output logic        [gqld_pkg::PROD_W-1:0]  product
);

   localparam int PP_W = 32 + gqld_pkg::HALF_B;

   logic [gqld_pkg::OPA_W-1:0]  a_mag_ff, a_mag_in;
   logic [gqld_pkg::OPB_W-1:0]  b_mag_ff, b_mag_in;
   logic                        neg_ff;
   logic [gqld_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [1:0]                  step_ff;
   logic                        run_ff, fin_ff, done_ff;
   logic signed [gqld_pkg::LD_W-1:0] result_ff, result_in;

   logic [31:0]                 a_part;
   logic [gqld_pkg::HALF_B-1:0] b_part;
   logic [PP_W-1:0]             pp;
   logic [gqld_pkg::PROD_W-1:0] pp_shifted;
   logic                        ovf;
   logic [gqld_pkg::LD_W-2:0]   mag;

   assign a_mag_in = op_a[gqld_pkg::OPA_W-1] ? gqld_pkg::OPA_W'(-op_a) : gqld_pkg::OPA_W'(op_a);
   assign b_mag_in = op_b[gqld_pkg::OPB_W-1] ? gqld_pkg::OPB_W'(-op_b) : gqld_pkg::OPB_W'(op_b);

   assign a_part = step_ff[1] ? a_mag_ff[63:32] : a_mag_ff[31:0];
   assign b_part = step_ff[0] ? b_mag_ff[gqld_pkg::OPB_W-1:gqld_pkg::HALF_B]
                              : b_mag_ff[gqld_pkg::HALF_B-1:0];
   assign pp     = PP_W'(a_part * b_part);

   always_comb begin
      unique case (step_ff)
         2'd0:    pp_shifted = gqld_pkg::PROD_W'(pp);
         2'd1:    pp_shifted = gqld_pkg::PROD_W'(pp) << gqld_pkg::HALF_B;
         2'd2:    pp_shifted = gqld_pkg::PROD_W'(pp) << 32;
         2'd3:    pp_shifted = gqld_pkg::PROD_W'(pp) << (32 + gqld_pkg::HALF_B);
         default: pp_shifted = '0;
      endcase
   end

   assign acc_in = acc_ff + pp_shifted;

   // product >> 16 must stay below 2^63
   assign ovf = |acc_ff[gqld_pkg::PROD_W-1:gqld_pkg::LD_W+15];
   assign mag = acc_ff[gqld_pkg::LD_W+14:16];

   always_comb begin
      if (ovf) begin
         result_in = neg_ff ? gqld_pkg::LD_MIN : gqld_pkg::LD_MAX;
      end else if (neg_ff) begin
         result_in = -$signed({1'b0, mag});
      end else begin
         result_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && (step_ff == 2'd3);
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (step_ff == 2'd3)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_mag_ff <= a_mag_in;
         b_mag_ff <= b_mag_in;
         neg_ff   <= op_a[gqld_pkg::OPA_W-1] ^ op_b[gqld_pkg::OPB_W-1];
         acc_ff   <= '0;
         step_ff  <= 2'd0;
      end else if (run_ff) begin
         acc_ff  <= acc_in;
         step_ff <= step_ff + 2'd1;
      end
      if (fin_ff) begin
         result_ff <= result_in;
      end
   end

   assign done    = done_ff;
   assign result  = result_ff;
   assign product = acc_ff;

endmodule

[rtl/gqld_div.sv]
// gqld_div: restoring divider, one quotient bit a cycle, for the mixing term
// divides a squared magnitude by a signed variance with saturation; uses gqld_pkg

module gqld_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic        [gqld_pkg::PROD_W-1:0] num,
   input  logic signed [gqld_pkg::VALUE_W-1:0] divisor,
   output logic                               done,
   output logic signed [gqld_pkg::LD_W-1:0]   result
);

   localparam int HI_W  = gqld_pkg::PROD_W - gqld_pkg::LD_W;
   localparam int CNT_W = $clog2(gqld_pkg::LD_W);

   logic [gqld_pkg::VALUE_W-1:0] dv_ff, dv_in;
   logic [gqld_pkg::VALUE_W-1:0] rem_ff, rem_in;
   logic [gqld_pkg::LD_W-1:0]    lo_ff, quo_ff, quo_in;
   logic                         neg_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         run_ff, fin_ff, done_ff;
   logic signed [gqld_pkg::LD_W-1:0] result_ff, result_in;

   logic [gqld_pkg::VALUE_W:0]   trial;
   logic                         ge;
   logic                         zero_div, early_sat;

   assign dv_in     = divisor[gqld_pkg::VALUE_W-1] ? gqld_pkg::VALUE_W'(-divisor)
                                                   : gqld_pkg::VALUE_W'(divisor);
   assign zero_div  = (divisor == '0);
   assign early_sat = (num[gqld_pkg::PROD_W-1:gqld_pkg::LD_W] >= HI_W'(dv_in));

   assign trial  = {rem_ff, lo_ff[gqld_pkg::LD_W-1]};
   assign ge     = (trial >= {1'b0, dv_ff});
   assign rem_in = ge ? gqld_pkg::VALUE_W'(trial - {1'b0, dv_ff}) : trial[gqld_pkg::VALUE_W-1:0];
   assign quo_in = {quo_ff[gqld_pkg::LD_W-2:0], ge};

   always_comb begin
      if (quo_ff[gqld_pkg::LD_W-1]) begin
         result_in = neg_ff ? gqld_pkg::LD_MIN : gqld_pkg::LD_MAX;
      end else if (neg_ff) begin
         result_in = -$signed(quo_ff);
      end else begin
         result_in = $signed(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff || (start && (zero_div || early_sat));
         fin_ff  <= run_ff && (cnt_ff == CNT_W'(gqld_pkg::LD_W - 1));
         if (start) begin
            run_ff <= !(zero_div || early_sat);
         end else if (run_ff && (cnt_ff == CNT_W'(gqld_pkg::LD_W - 1))) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dv_ff  <= dv_in;
         rem_ff <= gqld_pkg::VALUE_W'(num[gqld_pkg::PROD_W-1:gqld_pkg::LD_W]);
         lo_ff  <= num[gqld_pkg::LD_W-1:0];
         quo_ff <= '0;
         neg_ff <= divisor[gqld_pkg::VALUE_W-1];
         cnt_ff <= '0;
         if (zero_div) begin
            result_ff <= gqld_pkg::LD_MAX;
         end else if (early_sat) begin
            result_ff <= divisor[gqld_pkg::VALUE_W-1] ? gqld_pkg::LD_MIN : gqld_pkg::LD_MAX;
         end
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         lo_ff  <= lo_ff << 1;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (fin_ff) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[test/gaussian_quadratic_log_density_top_test.sv]
// self-checking bench for gaussian_quadratic_log_density_top: stimulus table, then random phases
// depends on gqld_pkg, the gqld interfaces and the top level; results checked against a local predictor
`timescale 1ns / 1ps

module gaussian_quadratic_log_density_top_test;
   import gqld_pkg::*;

   localparam int BINS = 16;
   localparam longint HALF_NEG = -64'sd4611686018427387903;   // -(max/2)

   typedef struct {
      bit             computed;
      longint         now_val;
      longint         prop_val;
   } density_t;

   // one row of the directed table: either a register write or a request
   typedef struct {
      bit                    is_csr;
      csr_index_type         reg_idx;
      logic [4:0]            reg_val;
      req_kind_type          kind;
      logic [9:0]            idx;
      logic signed [31:0]    val;
      logic [15:0]           cnt;
      logic signed [16:0]    chg;
      logic [19:0]           mix_n;
      logic [19:0]           mix_p;
      bit                    typed;
      bit                    want_computed;
      longint                want_now;
      longint                want_prop;
   } row_t;

   logic clock;
   logic reset;
   bit   steady;          // no idling on either side while set
   int   mismatch_count;

   gqld_req_if req_bus();
   gqld_rsp_if rsp_bus();
   gqld_csr_if csr_bus();

   gaussian_quadratic_log_density_top #(.MAX_BINS(BINS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // ---------------------------------------------------------------- predictor state
   longint mean_mem [2*BINS+1];
   longint prec_mem [2*BINS*BINS+1];
   longint count_mem [2*BINS];
   longint change_mem[2*BINS];
   logic [4:0] cfg_len;
   logic [2:0] cfg_marginal, cfg_joint_a, cfg_joint_b, cfg_mixing;

   density_t pending_densities[$];

   // ---------------------------------------------------------------- predictor arithmetic
   function automatic logic [63:0] magn(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   // saturate an unsigned magnitude to a signed 64-bit value
   function automatic longint clamp_signed(logic [127:0] m, bit neg);
      if (m[127:63] != 0) begin
         return neg ? LD_MIN : LD_MAX;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   // q.16 product, magnitude truncated
   function automatic longint q16_product(longint a, longint b);
      logic [127:0] p;
      p = {64'b0, magn(a)} * {64'b0, magn(b)};
      return clamp_signed(p >> 16, (a < 0) != (b < 0));
   endfunction

   function automatic longint sum_clamped(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? LD_MIN : LD_MAX;
      end
      return s[63:0];
   endfunction

   // d*d / var, zero variance gives the top value
   function automatic longint mixing_term(longint d, longint var_q);
      logic [127:0] dd, q;
      logic [63:0]  dv;
      if (var_q == 0) begin
         return LD_MAX;
      end
      dd = {64'b0, magn(d)} * {64'b0, magn(d)};
      dv = magn(var_q);
      if (dd[127:64] >= dv) begin
         return var_q < 0 ? LD_MIN : LD_MAX;
      end
      q = dd / {64'b0, dv};
      return clamp_signed(q, var_q < 0);
   endfunction

   function automatic longint block_quadratic(longint x[BINS], int len, int base);
      longint q, inner;
      q = 0;
      for (int i = 0; i < len; i++) begin
         inner = 0;
         for (int j = 0; j < len; j++) begin
            inner = sum_clamped(inner, q16_product(prec_mem[base + i*len + j], x[j]));
         end
         q = sum_clamped(q, q16_product(inner, x[i]));
      end
      return q;
   endfunction

   function automatic longint log_density_of(int len, bit proposed, logic [19:0] mix);
      longint x1[BINS], x2[BINS];
      longint c1, c2, s, d;
      for (int j = 0; j < len; j++) begin
         c1 = count_mem[j];
         c2 = count_mem[len + j];
         if (proposed) begin
            c1 += change_mem[j];
            c2 += change_mem[len + j];
         end
         x1[j] = c1 * 65536 - mean_mem[j];
         x2[j] = c2 * 65536 - mean_mem[len + j];
      end
      s = block_quadratic(x1, len, 0);
      s = sum_clamped(s, block_quadratic(x2, len, len*len));
      d = longint'(mix) * 65536 - mean_mem[2*len];
      s = sum_clamped(s, mixing_term(d, prec_mem[2*len*len]));
      return -(s / 2);
   endfunction

   function automatic density_t predict_density(logic [19:0] mix_n, logic [19:0] mix_p);
      density_t r;
      int len;
      len = cfg_len > BINS ? BINS : int'(cfg_len);
      r = '{0, 0, 0};
      if ((cfg_marginal == MARGINAL_GAUSS_A || cfg_marginal == MARGINAL_GAUSS_B) &&
          cfg_joint_a == JOINT_NONE && cfg_joint_b == JOINT_NONE &&
          cfg_mixing != MIXING_NONE) begin
         r.computed = 1;
         r.now_val  = log_density_of(len, 0, mix_n);
         r.prop_val = log_density_of(len, 1, mix_p);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- clock, reset, timeout
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------- result side
   always @(posedge clock) begin
      density_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_densities.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transaction, actual %b %h %h", $time,
                        rsp_bus.computed, rsp_bus.log_density_now, rsp_bus.log_density_prop);
            end else begin
               want = pending_densities.pop_front();
               if (rsp_bus.computed !== want.computed) begin
                  mismatch_count++;
                  $display("%0t: computed expected %b actual %b", $time,
                           want.computed, rsp_bus.computed);
               end
               if (rsp_bus.log_density_now !== want.now_val) begin
                  mismatch_count++;
                  $display("%0t: log_density_now expected %h actual %h", $time,
                           want.now_val, rsp_bus.log_density_now);
               end
               if (rsp_bus.log_density_prop !== want.prop_val) begin
                  mismatch_count++;
                  $display("%0t: log_density_prop expected %h actual %h", $time,
                           want.prop_val, rsp_bus.log_density_prop);
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 23);
      end
   end

   // ---------------------------------------------------------------- request side
   // raise valid with the payload, wait for the transaction, update the predictor;
   // valid is left high so a following item follows without a gap
   task automatic send_item(req_kind_type kind, logic [9:0] idx, logic signed [31:0] val,
                            logic [15:0] cnt, logic signed [16:0] chg,
                            logic [19:0] mix_n, logic [19:0] mix_p, bit typed,
                            density_t want);
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.index        <= idx;
      req_bus.value        <= val;
      req_bus.count_now    <= cnt;
      req_bus.count_change <= chg;
      req_bus.mix_now      <= mix_n;
      req_bus.mix_prop     <= mix_p;
      do @(posedge clock); while (!req_bus.ready);
      case (kind)
         REQ_LOAD_MEAN: if (idx < 2*BINS+1) mean_mem[idx] = val;
         REQ_LOAD_PREC: if (idx < 2*BINS*BINS+1) prec_mem[idx] = val;
         REQ_LOAD_STAT: begin
            if (idx < 2*BINS) begin
               count_mem[idx]  = cnt;
               change_mem[idx] = chg;
            end
         end
         default: begin
            if (!typed) begin
               want = predict_density(mix_n, mix_p);
            end
            pending_densities.push_back(want);
         end
      endcase
   endtask

   // random gap before an item
   task automatic maybe_idle();
      if (!steady && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 23);
      end
   endtask

   // the block is idle once every result is in; the task still waits out a margin
   // of idle clocks after the last result
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_densities.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type ridx, logic [4:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= ridx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (ridx)
         CSR_ACTIVE_LENGTH: cfg_len      = data;
         CSR_MARGINAL_KIND: cfg_marginal = data[2:0];
         CSR_JOINT_KIND_A:  cfg_joint_a  = data[2:0];
         CSR_JOINT_KIND_B:  cfg_joint_b  = data[2:0];
         default:           cfg_mixing   = data[2:0];
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly small q16.16 values so the sums stay meaningful, with extremes and full words
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 32'sh8000_0000;
      if (r < 10) return 32'sh7fff_ffff;
      if (r < 30) return $urandom;
      return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
   endfunction

   function automatic logic [19:0] pick_mix();
      return $urandom_range(1) ? 20'($urandom_range(20)) : 20'($urandom);
   endfunction

   // ---------------------------------------------------------------- stimulus
   row_t directed[27];

   initial begin
      density_t none;
      int le, cp, r, kind_i;
      logic [9:0] idx;
      logic [4:0] len_pick;
      req_kind_type kind;
      bit noise;

      none = '{0, 0, 0};
      mismatch_count = 0;
      steady = 0;
      reset  = 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= REQ_LOAD_MEAN;
      req_bus.index        <= '0;
      req_bus.value        <= '0;
      req_bus.count_now    <= '0;
      req_bus.count_change <= '0;
      req_bus.mix_now      <= '0;
      req_bus.mix_prop     <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_ACTIVE_LENGTH;
      csr_bus.data         <= '0;
      cfg_len = 16;
      cfg_marginal = 1;
      cfg_joint_a = 0;
      cfg_joint_b = 0;
      cfg_mixing = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every store entry once so no compute ever reads an unwritten word
      for (int i = 0; i < 2*BINS+1; i++)
         send_item(REQ_LOAD_MEAN, i, $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                   0, 0, 0, 0, 0, none);
      for (int i = 0; i < 2*BINS*BINS+1; i++)
         send_item(REQ_LOAD_PREC, i, $signed($urandom_range(0, 1 << 17)) - (1 << 16),
                   0, 0, 0, 0, 0, none);
      for (int i = 0; i < 2*BINS; i++)
         send_item(REQ_LOAD_STAT, i, 0, $urandom_range(20),
                   $signed($urandom_range(10)) - 5, 0, 0, 0, none);

      // directed table: kinds that refuse, zero variance, zero and oversize length,
      // field extremes and ignored out-of-range loads
      directed = '{
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 0, 20'hfffff, 0, 0, 0, 0},
         '{1, CSR_MIXING_KIND,   0, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 7, 9, 1, 0, 0, 0},
         '{1, CSR_MIXING_KIND,   7, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{1, CSR_MARGINAL_KIND, 0, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 1, 2, 1, 0, 0, 0},
         '{1, CSR_MARGINAL_KIND, 2, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{1, CSR_JOINT_KIND_A,  7, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 3, 4, 1, 0, 0, 0},
         '{1, CSR_JOINT_KIND_A,  0, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{1, CSR_JOINT_KIND_B,  1, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 5, 6, 1, 0, 0, 0},
         '{1, CSR_JOINT_KIND_B,  0, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{1, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_PREC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 5, 0, 1, 1, HALF_NEG, HALF_NEG},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_PREC, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 20'hfffff, 20'hfffff,
           1, 1, HALF_NEG, HALF_NEG},
         '{1, CSR_ACTIVE_LENGTH, 1, REQ_COMPUTE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_MEAN, 0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_PREC, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_STAT, 0, 0, 16'hffff, -17'sd65536, 0, 0,
           0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 0, 20'hfffff, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_MEAN, 10'h3ff, 32'sh7fff_ffff, 0, 0, 0, 0,
           0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_LOAD_STAT, 10'h3ff, 0, 16'h1234, 17'sd77, 0, 0,
           0, 0, 0, 0},
         '{1, CSR_ACTIVE_LENGTH, 31, REQ_COMPUTE,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{0, CSR_ACTIVE_LENGTH, 0, REQ_COMPUTE,   0, 0, 0, 0, 2, 3, 0, 0, 0, 0}
      };
      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            drain();
            write_reg(directed[i].reg_idx, directed[i].reg_val);
         end else begin
            maybe_idle();
            send_item(directed[i].kind, directed[i].idx, directed[i].val, directed[i].cnt,
                      directed[i].chg, directed[i].mix_n, directed[i].mix_p,
                      directed[i].typed, '{directed[i].want_computed, directed[i].want_now,
                                           directed[i].want_prop});
         end
      end

      // random phases, each under its own register setting; most lengths are small
      // so computes stay short, a few phases take the full or an oversize length
      for (int ph = 0; ph < 20; ph++) begin
         drain();
         case (ph)
            3, 10:   len_pick = 16;
            7:       len_pick = 0;
            12:      len_pick = 31;
            default: len_pick = $urandom_range(1, 4);
         endcase
         write_reg(CSR_ACTIVE_LENGTH, len_pick);
         if ($urandom_range(99) < 20) begin
            write_reg(CSR_MARGINAL_KIND, $urandom_range(7));
            write_reg(CSR_JOINT_KIND_A, $urandom_range(7));
            write_reg(CSR_JOINT_KIND_B, $urandom_range(7));
            write_reg(CSR_MIXING_KIND, $urandom_range(7));
         end else begin
            write_reg(CSR_MARGINAL_KIND, $urandom_range(1, 2));
            write_reg(CSR_JOINT_KIND_A, JOINT_NONE);
            write_reg(CSR_JOINT_KIND_B, JOINT_NONE);
            write_reg(CSR_MIXING_KIND, $urandom_range(1, 7));
         end
         steady = (ph == 5 || ph == 6);
         le = len_pick > BINS ? BINS : int'(len_pick);
         cp = le > 4 ? 4 : 25;
         for (int n = 0; n < 50; n++) begin
            r = $urandom_range(99);
            noise = 0;
            if (r < cp) begin
               kind = REQ_COMPUTE;
               idx  = $urandom;
            end else begin
               kind_i = $urandom_range(2);
               kind = req_kind_type'(kind_i);
               // noise: any index, mostly out of range and so ignored
               noise = (r < cp + 8);
               case (kind)
                  REQ_LOAD_MEAN: idx = $urandom_range(2*le);
                  REQ_LOAD_PREC: idx = $urandom_range(2*le*le);
                  default:       idx = $urandom_range(2*BINS - 1);
               endcase
               if (noise) idx = $urandom;
            end
            maybe_idle();
            send_item(kind, idx, pick_value(),
                      $urandom_range(2) != 0 ? 16'($urandom_range(20)) : 16'($urandom),
                      $urandom_range(2) != 0 ? 17'($signed($urandom_range(10)) - 5)
                                             : 17'($urandom),
                      pick_mix(), pick_mix(), 0, none);
         end
      end
      steady = 0;

      // let the last results in, then a margin for anything left running
      req_bus.valid <= 1'b0;
      while (pending_densities.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/gqld_pkg.sv
rtl/gqld_if.sv
rtl/gqld_mulq.sv
rtl/gqld_div.sv
rtl/gaussian_quadratic_log_density_top.sv
test/gaussian_quadratic_log_density_top_test.sv
